[hw/rtl/graph_edge_table_assert.svh]
// ----------------------------------------------------------------------------
// Graph edge table assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_EDGE_TABLE_ASSERT_SVH
`define GRAPH_EDGE_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge.
`define GEDT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define GEDT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/gedt_pkg.sv]
// ----------------------------------------------------------------------------
// Graph edge table package
// Sizes, codes and beat types shared by the table ring cells and the top level.
// ----------------------------------------------------------------------------
package gedt_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 128;
  localparam int ID_BITS   = 16;

  localparam int ID_W     = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int NCNT_W   = $clog2(MAX_NODES + 1);
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int SCAN_LEN = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int CNT_W    = $clog2(SCAN_LEN + 1);
  localparam int NIDX_W   = $clog2(MAX_NODES);

  typedef enum logic [3:0] {
    MODE_ADD_NODE  = 4'd0,
    MODE_ADD_EDGE  = 4'd1,
    MODE_ADD_BOTH  = 4'd2,
    MODE_RM_NODE   = 4'd3,
    MODE_RM_EDGE   = 4'd4,
    MODE_CONTAINS  = 4'd5,
    MODE_DEGREE    = 4'd6,
    MODE_MAX_DEG   = 4'd7,
    MODE_CLEAR     = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_DUP      = 3'd1,
    STS_SELF     = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] node_a;
    logic [15:0] node_b;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [7:0] degree;
    logic [6:0] node_count;
    logic [7:0] edge_count;
  } out_t;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
  } node_ent_t;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
  } edge_ent_t;

endpackage

[hw/rtl/gedt_node_cell.sv]
// ----------------------------------------------------------------------------
// Graph edge table node cell
// One slot of the node ring: a valid bit and a node id, passed on when shifted.
// ----------------------------------------------------------------------------
module gedt_node_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                clear_i,
  input  gedt_pkg::node_ent_t ent_i,
  output gedt_pkg::node_ent_t ent_o
);

  logic                      vld_q;
  logic [gedt_pkg::ID_W-1:0] id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= ent_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= ent_i.id;
    end
  end

  assign ent_o = '{vld: vld_q, id: id_q};

endmodule

[hw/rtl/gedt_edge_cell.sv]
// ----------------------------------------------------------------------------
// Graph edge table edge cell
// One slot of the edge ring: a valid bit and both endpoints, passed on when shifted.
// ----------------------------------------------------------------------------
module gedt_edge_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                clear_i,
  input  gedt_pkg::edge_ent_t ent_i,
  output gedt_pkg::edge_ent_t ent_o
);

  logic                      vld_q;
  logic [gedt_pkg::ID_W-1:0] a_q;
  logic [gedt_pkg::ID_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= ent_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      a_q <= ent_i.a;
      b_q <= ent_i.b;
    end
  end

  assign ent_o = '{vld: vld_q, a: a_q, b: b_q};

endmodule

[hw/rtl/graph_edge_table.sv]
// ----------------------------------------------------------------------------
// Graph edge table
// Undirected graph store with node and edge tables held in rotating cell rings.
// ----------------------------------------------------------------------------
// The node and edge tables are rings of cells that rotate one slot per cycle
// while shifted; all matching, inserting and removing happens at the ring tail,
// so one request is handled at a time. A request goes through one full rotation
// to look up, a decision step, one rotation to apply changes, and a step to post
// the result. Clear and unused modes go straight to posting the result. A
// maximum-degree query walks the node ring and, for each stored node, rotates
// the whole edge ring. A finished result sits in the output register until
// taken, and the next request beat is accepted meanwhile.
module graph_edge_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gedt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gedt_pkg::out_t out_data_o
);

  localparam int ID_W   = gedt_pkg::ID_W;
  localparam int NCNT_W = gedt_pkg::NCNT_W;
  localparam int ECNT_W = gedt_pkg::ECNT_W;
  localparam int CNT_W  = gedt_pkg::CNT_W;
  localparam int NIDX_W = gedt_pkg::NIDX_W;
  localparam int NN     = gedt_pkg::MAX_NODES;
  localparam int NE     = gedt_pkg::MAX_EDGES;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_MAXN  = 7'b0010000,
    S_MAXE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic ins_e;
    logic ins_na;
    logic ins_nb;
    logic rm_na;
    logic rm_inc;
    logic rm_eab;
  } pend_t;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NIDX_W-1:0]     nk_q, nk_d;
  logic [ECNT_W-1:0]     acc_q, acc_d, max_q, max_d, dcnt_q, dcnt_d, dgo_q, dgo_d;
  logic [ID_W-1:0]       cur_q, cur_d, ia_q, ia_d, ib_q, ib_d;
  logic [3:0]            mode_q, mode_d;
  logic                  f_na_q, f_na_d, f_nb_q, f_nb_d, f_ab_q, f_ab_d, f_ba_q, f_ba_d;
  logic [NCNT_W-1:0]     ncnt_q, ncnt_d;
  logic [ECNT_W-1:0]     ecnt_q, ecnt_d;
  pend_t                 pend_q, pend_d;
  gedt_pkg::status_e     sts_q, sts_d;
  logic                  fnd_q, fnd_d;
  gedt_pkg::out_t        out_q;
  logic                  out_vld_q;

  logic                  e_shift, n_shift, clr;
  gedt_pkg::edge_ent_t   e_cell [NE];
  gedt_pkg::node_ent_t   n_cell [NN];
  gedt_pkg::edge_ent_t   e_tail, e_feed;
  gedt_pkg::node_ent_t   n_tail, n_feed;
  logic                  hit_a, hit_cur;
  logic [ECNT_W-1:0]     acc_nx, mx;
  logic [NCNT_W:0]       need_tot;
  logic                  out_load;

  // Cell rings: cell 0 takes the (possibly rewritten) tail entry.
  for (genvar i = 0; i < NE; i++) begin : g_edge
    if (i == 0) begin : g_head
      gedt_edge_cell u_cell (.clk_i, .rst_ni, .shift_i(e_shift), .clear_i(clr),
                             .ent_i(e_feed), .ent_o(e_cell[i]));
    end else begin : g_body
      gedt_edge_cell u_cell (.clk_i, .rst_ni, .shift_i(e_shift), .clear_i(clr),
                             .ent_i(e_cell[i-1]), .ent_o(e_cell[i]));
    end
  end

  for (genvar i = 0; i < NN; i++) begin : g_node
    if (i == 0) begin : g_head
      gedt_node_cell u_cell (.clk_i, .rst_ni, .shift_i(n_shift), .clear_i(clr),
                             .ent_i(n_feed), .ent_o(n_cell[i]));
    end else begin : g_body
      gedt_node_cell u_cell (.clk_i, .rst_ni, .shift_i(n_shift), .clear_i(clr),
                             .ent_i(n_cell[i-1]), .ent_o(n_cell[i]));
    end
  end

  assign e_tail  = e_cell[NE-1];
  assign n_tail  = n_cell[NN-1];
  assign hit_a   = e_tail.vld && (e_tail.a == ia_q || e_tail.b == ia_q);
  assign hit_cur = e_tail.vld && (e_tail.a == cur_q || e_tail.b == cur_q);
  assign acc_nx  = acc_q + ECNT_W'(hit_cur);
  assign mx      = (acc_nx > max_q) ? acc_nx : max_q;
  assign need_tot = (NCNT_W+1)'(ncnt_q) + (NCNT_W+1)'(!f_na_q) + (NCNT_W+1)'(!f_nb_q);
  assign out_load = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nk_d    = nk_q;
    acc_d   = acc_q;
    max_d   = max_q;
    dcnt_d  = dcnt_q;
    dgo_d   = dgo_q;
    cur_d   = cur_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    mode_d  = mode_q;
    f_na_d  = f_na_q;
    f_nb_d  = f_nb_q;
    f_ab_d  = f_ab_q;
    f_ba_d  = f_ba_q;
    ncnt_d  = ncnt_q;
    ecnt_d  = ecnt_q;
    pend_d  = pend_q;
    sts_d   = sts_q;
    fnd_d   = fnd_q;
    e_shift = 1'b0;
    n_shift = 1'b0;
    clr     = 1'b0;
    e_feed  = e_tail;
    n_feed  = n_tail;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_data_i.mode;
          ia_d   = in_data_i.node_a[ID_W-1:0];
          ib_d   = in_data_i.node_b[ID_W-1:0];
          f_na_d = 1'b0;
          f_nb_d = 1'b0;
          f_ab_d = 1'b0;
          f_ba_d = 1'b0;
          dcnt_d = '0;
          cnt_d  = '0;
          nk_d   = '0;
          max_d  = '0;
          pend_d = '0;
          sts_d  = gedt_pkg::STS_OK;
          fnd_d  = 1'b0;
          dgo_d  = '0;
          case (in_data_i.mode) inside
            gedt_pkg::MODE_CLEAR: begin
              clr     = 1'b1;
              ncnt_d  = '0;
              ecnt_d  = '0;
              state_d = S_DONE;
            end
            gedt_pkg::MODE_MAX_DEG: state_d = S_MAXN;
            gedt_pkg::MODE_ADD_NODE, gedt_pkg::MODE_ADD_EDGE, gedt_pkg::MODE_ADD_BOTH,
            gedt_pkg::MODE_RM_NODE, gedt_pkg::MODE_RM_EDGE, gedt_pkg::MODE_CONTAINS,
            gedt_pkg::MODE_DEGREE: state_d = S_SCAN;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        e_shift = (cnt_q < CNT_W'(NE));
        n_shift = (cnt_q < CNT_W'(NN));
        if (e_shift && e_tail.vld) begin
          if (e_tail.a == ia_q && e_tail.b == ib_q) f_ab_d = 1'b1;
          if (e_tail.a == ib_q && e_tail.b == ia_q) f_ba_d = 1'b1;
          if (hit_a) dcnt_d = dcnt_q + ECNT_W'(1);
        end
        if (n_shift && n_tail.vld) begin
          if (n_tail.id == ia_q) f_na_d = 1'b1;
          if (n_tail.id == ib_q) f_nb_d = 1'b1;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(gedt_pkg::SCAN_LEN - 1)) begin
          cnt_d   = '0;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_APPLY;
        case (mode_q)
          gedt_pkg::MODE_ADD_NODE: begin
            if (f_na_q) begin
              sts_d = gedt_pkg::STS_DUP;
            end else if (ncnt_q >= NCNT_W'(NN)) begin
              sts_d = gedt_pkg::STS_FULL;
            end else begin
              pend_d.ins_na = 1'b1;
              ncnt_d        = ncnt_q + NCNT_W'(1);
              fnd_d         = 1'b1;
            end
          end
          gedt_pkg::MODE_ADD_EDGE, gedt_pkg::MODE_ADD_BOTH: begin
            if (ia_q == ib_q) begin
              sts_d = gedt_pkg::STS_SELF;
            end else if (f_ab_q) begin
              sts_d = gedt_pkg::STS_DUP;
            end else if (ecnt_q >= ECNT_W'(NE)) begin
              sts_d = gedt_pkg::STS_FULL;
            end else if (mode_q == gedt_pkg::MODE_ADD_BOTH &&
                         need_tot > (NCNT_W+1)'(NN)) begin
              sts_d = gedt_pkg::STS_FULL;
            end else begin
              pend_d.ins_e = 1'b1;
              ecnt_d       = ecnt_q + ECNT_W'(1);
              fnd_d        = 1'b1;
              if (mode_q == gedt_pkg::MODE_ADD_BOTH) begin
                pend_d.ins_na = !f_na_q;
                pend_d.ins_nb = !f_nb_q;
                ncnt_d        = NCNT_W'(need_tot);
              end
            end
          end
          gedt_pkg::MODE_RM_NODE: begin
            if (!f_na_q) begin
              sts_d = gedt_pkg::STS_NOTFOUND;
            end else begin
              pend_d.rm_na  = 1'b1;
              pend_d.rm_inc = 1'b1;
              ncnt_d        = ncnt_q - NCNT_W'(1);
              // Every edge touching the node goes, and that is its degree.
              ecnt_d        = ecnt_q - dcnt_q;
            end
          end
          gedt_pkg::MODE_RM_EDGE: begin
            if (!f_ab_q) begin
              sts_d = gedt_pkg::STS_NOTFOUND;
            end else begin
              pend_d.rm_eab = 1'b1;
              ecnt_d        = ecnt_q - ECNT_W'(1);
            end
          end
          gedt_pkg::MODE_CONTAINS: fnd_d = f_ab_q || f_ba_q;
          gedt_pkg::MODE_DEGREE: begin
            dgo_d = dcnt_q;
            if (dcnt_q == '0) sts_d = gedt_pkg::STS_NOTFOUND;
          end
          default: ;
        endcase
      end

      S_APPLY: begin
        e_shift = (cnt_q < CNT_W'(NE));
        n_shift = (cnt_q < CNT_W'(NN));
        if (e_tail.vld) begin
          if (pend_q.rm_inc && hit_a) e_feed.vld = 1'b0;
          if (pend_q.rm_eab && e_tail.a == ia_q && e_tail.b == ib_q) e_feed.vld = 1'b0;
        end else if (e_shift && pend_q.ins_e) begin
          e_feed       = '{vld: 1'b1, a: ia_q, b: ib_q};
          pend_d.ins_e = 1'b0;
        end
        if (n_tail.vld) begin
          if (pend_q.rm_na && n_tail.id == ia_q) n_feed.vld = 1'b0;
        end else if (n_shift && pend_q.ins_na) begin
          n_feed        = '{vld: 1'b1, id: ia_q};
          pend_d.ins_na = 1'b0;
        end else if (n_shift && pend_q.ins_nb) begin
          n_feed        = '{vld: 1'b1, id: ib_q};
          pend_d.ins_nb = 1'b0;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(gedt_pkg::SCAN_LEN - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end

      S_MAXN: begin
        if (n_tail.vld) begin
          cur_d   = n_tail.id;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MAXE;
        end else begin
          n_shift = 1'b1;
          if (nk_q == NIDX_W'(NN - 1)) begin
            dgo_d   = max_q;
            state_d = S_DONE;
          end else begin
            nk_d = nk_q + NIDX_W'(1);
          end
        end
      end

      S_MAXE: begin
        e_shift = 1'b1;
        acc_d   = acc_nx;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NE - 1)) begin
          max_d   = mx;
          n_shift = 1'b1;
          if (nk_q == NIDX_W'(NN - 1)) begin
            dgo_d   = mx;
            state_d = S_DONE;
          end else begin
            nk_d    = nk_q + NIDX_W'(1);
            state_d = S_MAXN;
          end
        end
      end

      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      nk_q      <= '0;
      ncnt_q    <= '0;
      ecnt_q    <= '0;
      pend_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nk_q    <= nk_d;
      ncnt_q  <= ncnt_d;
      ecnt_q  <= ecnt_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    max_q  <= max_d;
    dcnt_q <= dcnt_d;
    dgo_q  <= dgo_d;
    cur_q  <= cur_d;
    ia_q   <= ia_d;
    ib_q   <= ib_d;
    mode_q <= mode_d;
    f_na_q <= f_na_d;
    f_nb_q <= f_nb_d;
    f_ab_q <= f_ab_d;
    f_ba_q <= f_ba_d;
    sts_q  <= sts_d;
    fnd_q  <= fnd_d;
    if (out_load) begin
      out_q.status     <= sts_q;
      out_q.found      <= fnd_q;
      out_q.degree     <= (int'(dgo_q) > 255) ? 8'hFF : 8'(dgo_q);
      out_q.node_count <= 7'(ncnt_q);
      out_q.edge_count <= 8'(ecnt_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`include "graph_edge_table_assert.svh"

  `GEDT_ASSERT_ALWAYS(a_ncnt_max, ncnt_q <= NCNT_W'(NN), "node count above table size")
  `GEDT_ASSERT_ALWAYS(a_ecnt_max, ecnt_q <= ECNT_W'(NE), "edge count above table size")
  `GEDT_ASSERT_NEXT(a_ins_done,
    state_q == S_APPLY && cnt_q == CNT_W'(gedt_pkg::SCAN_LEN - 1),
    !pend_q.ins_e && !pend_q.ins_na && !pend_q.ins_nb, "insert found no free slot")

endmodule

[test/graph_edge_table_test.sv]
// ----------------------------------------------------------------------------
// Graph edge table testbench
// Drives request beats with random gaps and stalls, predicts every result from
// a local model of the node and edge tables, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_edge_table_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gedt_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gedt_pkg::out_t out_data_o;

  graph_edge_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the graph.
  logic [15:0] node_id_tab [gedt_pkg::MAX_NODES];
  logic        node_used   [gedt_pkg::MAX_NODES];
  logic [15:0] edge_a_tab  [gedt_pkg::MAX_EDGES];
  logic [15:0] edge_b_tab  [gedt_pkg::MAX_EDGES];
  logic        edge_used   [gedt_pkg::MAX_EDGES];
  int unsigned node_total;
  int unsigned edge_total;

  gedt_pkg::out_t expected_results [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  // Ids drawn from a small pool so that lookups hit often.
  logic [15:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                               16'h5555, 16'hAAAA, 16'h1234, 16'h00F0};

  function automatic int node_slot(logic [15:0] id);
    for (int i = 0; i < gedt_pkg::MAX_NODES; i++)
      if (node_used[i] && node_id_tab[i] == id) return i;
    return -1;
  endfunction

  function automatic int edge_slot(logic [15:0] a, logic [15:0] b);
    for (int i = 0; i < gedt_pkg::MAX_EDGES; i++)
      if (edge_used[i] && edge_a_tab[i] == a && edge_b_tab[i] == b) return i;
    return -1;
  endfunction

  function automatic int unsigned edges_touching(logic [15:0] id);
    int unsigned n = 0;
    for (int i = 0; i < gedt_pkg::MAX_EDGES; i++)
      if (edge_used[i] && (edge_a_tab[i] == id || edge_b_tab[i] == id)) n++;
    return n;
  endfunction

  function automatic void store_node(logic [15:0] id);
    for (int i = 0; i < gedt_pkg::MAX_NODES; i++)
      if (!node_used[i]) begin
        node_used[i] = 1'b1;
        node_id_tab[i] = id;
        node_total++;
        return;
      end
  endfunction

  function automatic void store_edge(logic [15:0] a, logic [15:0] b);
    for (int i = 0; i < gedt_pkg::MAX_EDGES; i++)
      if (!edge_used[i]) begin
        edge_used[i] = 1'b1;
        edge_a_tab[i] = a;
        edge_b_tab[i] = b;
        edge_total++;
        return;
      end
  endfunction

  function automatic gedt_pkg::status_e edge_add_status(logic [15:0] a, logic [15:0] b);
    if (a == b) return gedt_pkg::STS_SELF;
    if (edge_slot(a, b) >= 0) return gedt_pkg::STS_DUP;
    if (edge_total >= gedt_pkg::MAX_EDGES) return gedt_pkg::STS_FULL;
    return gedt_pkg::STS_OK;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < gedt_pkg::MAX_NODES; i++) node_used[i] = 1'b0;
    for (int i = 0; i < gedt_pkg::MAX_EDGES; i++) edge_used[i] = 1'b0;
    node_total = 0;
    edge_total = 0;
  endfunction

  function automatic gedt_pkg::out_t graph_update(gedt_pkg::in_t req);
    gedt_pkg::out_t r;
    gedt_pkg::status_e st = gedt_pkg::STS_OK;
    logic fnd = 1'b0;
    int unsigned deg = 0;
    int k;
    int unsigned need;
    case (req.mode)
      gedt_pkg::MODE_ADD_NODE: begin
        if (node_slot(req.node_a) >= 0) st = gedt_pkg::STS_DUP;
        else if (node_total >= gedt_pkg::MAX_NODES) st = gedt_pkg::STS_FULL;
        else begin
          store_node(req.node_a);
          fnd = 1'b1;
        end
      end
      gedt_pkg::MODE_ADD_EDGE: begin
        st = edge_add_status(req.node_a, req.node_b);
        if (st == gedt_pkg::STS_OK) begin
          store_edge(req.node_a, req.node_b);
          fnd = 1'b1;
        end
      end
      gedt_pkg::MODE_ADD_BOTH: begin
        st = edge_add_status(req.node_a, req.node_b);
        if (st == gedt_pkg::STS_OK) begin
          need = (node_slot(req.node_a) < 0) + (node_slot(req.node_b) < 0);
          if (node_total + need > gedt_pkg::MAX_NODES) st = gedt_pkg::STS_FULL;
          else begin
            store_edge(req.node_a, req.node_b);
            if (node_slot(req.node_a) < 0) store_node(req.node_a);
            if (node_slot(req.node_b) < 0) store_node(req.node_b);
            fnd = 1'b1;
          end
        end
      end
      gedt_pkg::MODE_RM_NODE: begin
        k = node_slot(req.node_a);
        if (k < 0) st = gedt_pkg::STS_NOTFOUND;
        else begin
          node_used[k] = 1'b0;
          node_total--;
          for (int i = 0; i < gedt_pkg::MAX_EDGES; i++)
            if (edge_used[i] && (edge_a_tab[i] == req.node_a ||
                                 edge_b_tab[i] == req.node_a)) begin
              edge_used[i] = 1'b0;
              edge_total--;
            end
        end
      end
      gedt_pkg::MODE_RM_EDGE: begin
        k = edge_slot(req.node_a, req.node_b);
        if (k < 0) st = gedt_pkg::STS_NOTFOUND;
        else begin
          edge_used[k] = 1'b0;
          edge_total--;
        end
      end
      gedt_pkg::MODE_CONTAINS:
        fnd = (edge_slot(req.node_a, req.node_b) >= 0) ||
              (edge_slot(req.node_b, req.node_a) >= 0);
      gedt_pkg::MODE_DEGREE: begin
        deg = edges_touching(req.node_a);
        if (deg == 0) st = gedt_pkg::STS_NOTFOUND;
      end
      gedt_pkg::MODE_MAX_DEG:
        for (int i = 0; i < gedt_pkg::MAX_NODES; i++)
          if (node_used[i] && edges_touching(node_id_tab[i]) > deg)
            deg = edges_touching(node_id_tab[i]);
      gedt_pkg::MODE_CLEAR: clear_graph();
      default: ;
    endcase
    if (deg > 255) deg = 255;
    r.status = st;
    r.found = fnd;
    r.degree = deg[7:0];
    r.node_count = node_total[6:0];
    r.edge_count = edge_total[7:0];
    return r;
  endfunction

  // Sends one request beat, with a random gap ahead of it. Valid stays high
  // after the accepting edge so that beats can follow back to back.
  task automatic send_request(logic [3:0] mode, logic [15:0] a, logic [15:0] b);
    gedt_pkg::in_t  req;
    gedt_pkg::out_t exp_r;
    req.mode = mode;
    req.node_a = a;
    req.node_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_r = graph_update(req);
    expected_results.insert(expected_results.size(), exp_r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        gedt_pkg::out_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_data_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_r, out_data_o);
        end
      end
    end
    if (cycles > 64'd3_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_id();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return id_pool[$urandom_range(7)];
  endfunction

  task automatic test_directed();
    send_request(gedt_pkg::MODE_MAX_DEG, 0, 0);
    send_request(gedt_pkg::MODE_ADD_NODE, 16'h0000, 0);
    send_request(gedt_pkg::MODE_ADD_NODE, 16'h0000, 0);
    send_request(gedt_pkg::MODE_ADD_NODE, 16'hFFFF, 0);
    send_request(gedt_pkg::MODE_ADD_EDGE, 16'h0000, 16'hFFFF);
    send_request(gedt_pkg::MODE_ADD_EDGE, 16'h0000, 16'hFFFF);
    send_request(gedt_pkg::MODE_ADD_EDGE, 16'hFFFF, 16'h0000);
    send_request(gedt_pkg::MODE_ADD_EDGE, 16'h1234, 16'h1234);
    send_request(gedt_pkg::MODE_ADD_BOTH, 16'hAAAA, 16'h5555);
    send_request(gedt_pkg::MODE_ADD_EDGE, 16'h7777, 16'h8888);
    send_request(gedt_pkg::MODE_CONTAINS, 16'h5555, 16'hAAAA);
    send_request(gedt_pkg::MODE_CONTAINS, 16'h5555, 16'h0000);
    send_request(gedt_pkg::MODE_DEGREE, 16'h0000, 0);
    send_request(gedt_pkg::MODE_DEGREE, 16'h7777, 0);
    send_request(gedt_pkg::MODE_DEGREE, 16'h4321, 0);
    send_request(gedt_pkg::MODE_ADD_NODE, 16'h4321, 0);
    send_request(gedt_pkg::MODE_MAX_DEG, 0, 0);
    send_request(gedt_pkg::MODE_RM_EDGE, 16'h5555, 16'hAAAA);
    send_request(gedt_pkg::MODE_RM_EDGE, 16'hAAAA, 16'h5555);
    send_request(gedt_pkg::MODE_RM_NODE, 16'hFFFF, 0);
    send_request(gedt_pkg::MODE_RM_NODE, 16'hFFFF, 0);
    send_request(4'd15, 16'hFFFF, 16'hFFFF);
    send_request(4'd9, 0, 0);
    send_request(gedt_pkg::MODE_CLEAR, 0, 0);
    wait_drained();
  endtask

  // Fills both tables to their limits to reach the full cases.
  task automatic test_full_tables();
    for (int i = 0; i < gedt_pkg::MAX_NODES + 1; i++)
      send_request(gedt_pkg::MODE_ADD_NODE, 16'(i * 3), 0);
    send_request(gedt_pkg::MODE_ADD_BOTH, 16'h9000, 16'h9001);
    send_request(gedt_pkg::MODE_ADD_BOTH, 16'h0000, 16'h9001);
    for (int i = 0; i < gedt_pkg::MAX_EDGES + 1; i++)
      send_request(gedt_pkg::MODE_ADD_EDGE, 16'h0000, 16'(i + 1));
    send_request(gedt_pkg::MODE_DEGREE, 16'h0000, 0);
    send_request(gedt_pkg::MODE_MAX_DEG, 0, 0);
    send_request(gedt_pkg::MODE_RM_NODE, 16'h0000, 0);
    send_request(gedt_pkg::MODE_CLEAR, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 2) send_request(gedt_pkg::MODE_MAX_DEG, 16'($urandom), 16'($urandom));
      else if (r < 3) send_request(gedt_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom));
      else if (r < 5) send_request(4'($urandom_range(15, 9)), 16'($urandom), 16'($urandom));
      else send_request(4'($urandom_range(6)), pick_id(), pick_id());
    end
    wait_drained();
  endtask

  initial begin
    clear_graph();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 24;
    recv_stall_pct = 57;
    test_directed();
    test_full_tables();
    test_random(450);
    send_idle_pct = 57;
    recv_stall_pct = 24;
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(450);
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
